/* design/bole_pkg.sv */
package bole_pkg;

	localparam int CAPACITY    = 32;
	localparam int VALUE_WIDTH = 32;

	// fixed field widths of the channels
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int ITEM_W   = 32;
	localparam int COUNT_W  = 6;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DELETE    = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_LIST      = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [ITEM_W-1:0] item;
		logic [COUNT_W-1:0]       count;
		logic                     last;
	} res_t;

	typedef struct packed {
		logic                   we;
		logic [IDX_W-1:0]       waddr;
		logic [VALUE_WIDTH-1:0] wdata;
		logic                   re;
		logic [IDX_W-1:0]       raddr;
	} ram_req_t;

	// input word narrowed or sign extended to the stored width
	function automatic logic [VALUE_WIDTH-1:0] to_stored(input logic signed [ITEM_W-1:0] v);
		to_stored = VALUE_WIDTH'(v);
	endfunction

	function automatic logic signed [ITEM_W-1:0] to_item(
		input logic signed [VALUE_WIDTH-1:0] v);
		to_item = ITEM_W'(v);
	endfunction

	// ring position of the k-th entry counted from the front
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] front,
		input logic [CNT_W-1:0] k);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(front) + (CNT_W+1)'(k);
		if (s >= (CNT_W+1)'(CAPACITY)) begin
			s = s - (CNT_W+1)'(CAPACITY);
		end
		slot = IDX_W'(s);
	endfunction

	function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] front);
		if (front == '0) begin
			slot_dec = IDX_W'(CAPACITY - 1);
		end else begin
			slot_dec = front - IDX_W'(1);
		end
	endfunction

endpackage

/* design/bole_in_if.sv */
interface bole_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [bole_pkg::OPCODE_W-1:0]        opcode;
	logic signed [bole_pkg::ITEM_W-1:0]   value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

/* design/bole_out_if.sv */
interface bole_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [bole_pkg::STATUS_W-1:0]        status;
	logic signed [bole_pkg::ITEM_W-1:0]   item;
	logic [bole_pkg::COUNT_W-1:0]         count;
	logic                                 last;

	modport source (output valid, output status, output item, output count, output last,
		input ready);
	modport sink (input valid, input status, input item, input count, input last,
		output ready);
endinterface

/* design/bole_ram.sv */
module bole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/bole_obuf.sv */
module bole_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  bole_pkg::res_t     res,
	output logic               res_room,
	bole_out_if.source         rsp
);

	logic           valid_q;
	bole_pkg::res_t data_q;

	assign res_room = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_room) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_room && res_valid) begin
			data_q <= res;
		end
	end

	assign rsp.valid  = valid_q;
	assign rsp.status = data_q.status;
	assign rsp.item   = data_q.item;
	assign rsp.count  = data_q.count;
	assign rsp.last   = data_q.last;

endmodule

/* design/bole_ctrl.sv */
module bole_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bole_in_if.sink                              cmd,
	output bole_pkg::ram_req_t                   ram_req,
	input  logic [bole_pkg::VALUE_WIDTH-1:0]     rdata,
	output logic                                 res_valid,
	output bole_pkg::res_t                       res,
	input  logic                                 res_room
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_LIST  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	localparam int CNT_W = bole_pkg::CNT_W;
	localparam int IDX_W = bole_pkg::IDX_W;
	localparam int VW    = bole_pkg::VALUE_WIDTH;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [VW-1:0]    key_q, key_d;
	bole_pkg::res_t   res_q, res_d;

	logic             acc, fire, full, empty, at_end, shift_done, match;
	logic [VW-1:0]    in_val;
	logic [IDX_W-1:0] front_dec;
	logic [CNT_W-1:0] k_nx, k_nx2, cnt_inc, cnt_dec;
	bole_pkg::res_t   list_res;

	assign cmd.ready  = (state_q == S_IDLE);
	assign acc        = cmd.valid && cmd.ready;
	assign in_val     = bole_pkg::to_stored(cmd.value);
	assign front_dec  = bole_pkg::slot_dec(front_q);
	assign k_nx       = k_q + CNT_W'(1);
	assign k_nx2      = k_q + CNT_W'(2);
	assign cnt_inc    = cnt_q + CNT_W'(1);
	assign cnt_dec    = cnt_q - CNT_W'(1);
	assign full       = (cnt_q == CNT_W'(bole_pkg::CAPACITY));
	assign empty      = (cnt_q == '0);
	assign at_end     = (k_nx == cnt_q);
	assign shift_done = (k_nx2 == cnt_q);
	// compare unit: the entry read last cycle against the key
	assign match      = (rdata == key_q);

	assign res_valid = (state_q == S_RESP) || (state_q == S_LIST);
	assign fire      = res_valid && res_room;

	always_comb begin
		list_res.status = bole_pkg::ST_OK;
		list_res.item   = bole_pkg::to_item(rdata);
		list_res.count  = bole_pkg::COUNT_W'(cnt_q);
		list_res.last   = at_end;
	end

	assign res = (state_q == S_LIST) ? list_res : res_q;

	// ram port control
	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = bole_pkg::slot(front_q, cnt_q);
		ram_req.wdata = in_val;
		ram_req.re    = 1'b0;
		ram_req.raddr = bole_pkg::slot(front_q, k_nx);
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (cmd.opcode)
						bole_pkg::OP_INS_FRONT: begin
							ram_req.we    = !full;
							ram_req.waddr = front_dec;
						end
						bole_pkg::OP_INS_BACK: begin
							ram_req.we = !full;
						end
						default: begin
							// delete and list both start reading at the front
							ram_req.re    = !empty;
							ram_req.raddr = front_q;
						end
					endcase
				end
			end
			S_SRCH: begin
				ram_req.re = !at_end;
			end
			S_SHIFT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = bole_pkg::slot(front_q, k_q);
				ram_req.wdata = rdata;
				ram_req.re    = !shift_done;
				ram_req.raddr = bole_pkg::slot(front_q, k_nx2);
			end
			S_LIST: begin
				ram_req.re = fire && !at_end;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		front_d = front_q;
		k_d     = k_q;
		key_d   = key_q;
		res_d   = res_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					key_d        = in_val;
					k_d          = '0;
					res_d.item   = bole_pkg::to_item(in_val);
					res_d.count  = bole_pkg::COUNT_W'(cnt_q);
					res_d.last   = 1'b1;
					state_d      = S_RESP;
					case (cmd.opcode)
						bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK: begin
							if (full) begin
								res_d.status = bole_pkg::ST_FULL;
							end else begin
								res_d.status = bole_pkg::ST_OK;
								res_d.count  = bole_pkg::COUNT_W'(cnt_inc);
								cnt_d        = cnt_inc;
								if (cmd.opcode == bole_pkg::OP_INS_FRONT) begin
									front_d = front_dec;
								end
							end
						end
						bole_pkg::OP_DELETE: begin
							res_d.status = bole_pkg::ST_EMPTY;
							if (!empty) begin
								state_d = S_SRCH;
							end
						end
						default: begin
							// list all
							res_d.status = bole_pkg::ST_EMPTY;
							res_d.item   = '0;
							if (!empty) begin
								state_d = S_LIST;
							end
						end
					endcase
				end
			end
			S_SRCH: begin
				if (match && at_end) begin
					cnt_d        = cnt_dec;
					res_d.status = bole_pkg::ST_OK;
					res_d.count  = bole_pkg::COUNT_W'(cnt_dec);
					state_d      = S_RESP;
				end else if (match) begin
					state_d = S_SHIFT;
				end else if (at_end) begin
					res_d.status = bole_pkg::ST_NOTFOUND;
					state_d      = S_RESP;
				end else begin
					k_d = k_nx;
				end
			end
			S_SHIFT: begin
				if (shift_done) begin
					cnt_d        = cnt_dec;
					res_d.status = bole_pkg::ST_OK;
					res_d.count  = bole_pkg::COUNT_W'(cnt_dec);
					state_d      = S_RESP;
				end else begin
					k_d = k_nx;
				end
			end
			S_LIST: begin
				if (fire) begin
					if (at_end) begin
						state_d = S_IDLE;
					end else begin
						k_d = k_nx;
					end
				end
			end
			S_RESP: begin
				if (fire) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			front_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			front_q <= front_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q   <= k_d;
		key_q <= key_d;
		res_q <= res_d;
	end

endmodule

/* design/bounded_ordered_list_engine.sv */
// insert, and delete or list on an empty store: the result is registered in the sequencer, then
// moved to the output register
// delete: after accept, entries are searched from the front and those behind a match moved up
// one place, then the result is handed over; a single ram port pair paces search and compaction
// list: entries from the front reach the output register one per cycle while it has room; the
// next word is taken once the last result has moved to the output register
// reset clears count, front index and the output valid flag; the entry ram is not cleared
module bounded_ordered_list_engine (
	input  logic       clk,
	input  logic       arst_n,
	bole_in_if.sink    cmd,
	bole_out_if.source rsp
);

	bole_pkg::ram_req_t                 ram_req;
	logic [bole_pkg::VALUE_WIDTH-1:0]   rdata;
	logic                               res_valid;
	logic                               res_room;
	bole_pkg::res_t                     res;

	bole_ram #(
		.WIDTH(bole_pkg::VALUE_WIDTH),
		.DEPTH(bole_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	bole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_req   (ram_req),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_room  (res_room)
	);

	bole_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_room  (res_room),
		.rsp       (rsp)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while previous word still in progress");

	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !cmd.ready)
		else $error("result offered while sequencer idle");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == bole_pkg::ST_FULL
		|-> res.count == bole_pkg::COUNT_W'(bole_pkg::CAPACITY))
		else $error("store full reported below capacity");

	a_last_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> res.status == bole_pkg::ST_OK)
		else $error("non-final result with error status");

	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)
		else $error("compaction reads the entry it writes");
`endif

endmodule
